// ----- rtl/awbg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awbg_pkg
// shared types and constants of the white balance gain calculation
// ----------------------------------------------------------------------------
package awbg_pkg;

	localparam int unsigned RATIO_W = 10;
	// light corrected ratio reaches 1023*1535/1024 = 1533, one bit wider
	localparam int unsigned CR_W    = RATIO_W + 1;
	localparam int unsigned GAIN_W  = 12;
	// dividends stay below 4095*1023 < 2^22, quotients likewise
	localparam int unsigned NUM_W   = 22;
	localparam int unsigned QUO_W   = 22;

	localparam logic [7:0]         VALID_MARK = 8'h31;
	localparam logic [GAIN_W-1:0]  UNITY_GAIN = 12'd1024;
	localparam logic [GAIN_W-1:0]  GAIN_MAX   = 12'd4095;
	localparam logic [RATIO_W:0]   LIGHT_OFFSET = 11'd512;

	localparam logic [1:0] REG_TYP_RED = 2'd0;
	localparam logic [1:0] REG_TYP_BLUE = 2'd1;
	localparam logic [1:0] REG_DEF_RED = 2'd2;
	localparam logic [1:0] REG_DEF_BLUE = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// restoring divider cell payload
	typedef struct packed {
		logic              vld;
		logic [NUM_W-1:0]  rem;   // partial remainder
		logic [NUM_W-1:0]  num;   // remaining dividend bits, msb first
		logic [QUO_W-1:0]  quo;
		logic [CR_W-1:0]   den;
	} div_cell_t;

	// item context travelling beside the dividers
	typedef struct packed {
		logic               zero_err;
		logic               used_def;
		logic [1:0]         mode;   // which channel holds unity
		logic [CR_W-1:0]    rg;
		logic [CR_W-1:0]    bg;
		logic [RATIO_W-1:0] tr;
		logic [RATIO_W-1:0] tb;
	} ctx_t;

	localparam logic [1:0] M_GREEN = 2'd0;
	localparam logic [1:0] M_RED   = 2'd1;
	localparam logic [1:0] M_BLUE  = 2'd2;
	// both ratios at or above typical, settled after the first division
	localparam logic [1:0] M_BOTH  = 2'd3;

endpackage

// ----- rtl/awbg_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awbg_div_cell
// one restoring division step, registered
// ----------------------------------------------------------------------------
module awbg_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  awbg_pkg::div_cell_t d,
	output awbg_pkg::div_cell_t q
);
	import awbg_pkg::*;

	logic [NUM_W:0]   trial;
	logic [NUM_W:0]   shifted;
	logic             vld_q;
	logic [NUM_W-1:0] rem_q, num_q;
	logic [QUO_W-1:0] quo_q;
	logic [CR_W-1:0]  den_q;

	assign shifted = {d.rem, d.num[NUM_W-1]};
	assign trial   = shifted - {{(NUM_W+1-CR_W){1'b0}}, d.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		den_q <= d.den;
		num_q <= {d.num[NUM_W-2:0], 1'b0};
		if (!trial[NUM_W]) begin
			rem_q <= trial[NUM_W-1:0];
			quo_q <= {d.quo[QUO_W-2:0], 1'b1};
		end else begin
			rem_q <= shifted[NUM_W-1:0];
			quo_q <= {d.quo[QUO_W-2:0], 1'b0};
		end
	end

	assign q = '{vld: vld_q, rem: rem_q, num: num_q, quo: quo_q, den: den_q};
endmodule

// ----- rtl/awbg_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awbg_divider
// chain of division cells with the item context carried alongside
// ----------------------------------------------------------------------------
module awbg_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [awbg_pkg::NUM_W-1:0]  num,
	input  logic [awbg_pkg::CR_W-1:0]   den,
	input  awbg_pkg::ctx_t              in_ctx,
	output logic                        out_vld,
	output logic [awbg_pkg::QUO_W-1:0]  quo,
	output awbg_pkg::ctx_t              out_ctx
);
	import awbg_pkg::*;

	div_cell_t chain [NUM_W+1];
	ctx_t      ctx_q [NUM_W+1];

	assign chain[0] = '{vld: in_vld, rem: '0, num: num, quo: '0, den: den};
	assign ctx_q[0] = in_ctx;

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		awbg_div_cell u_cell (.clk(clk), .arst_n(arst_n), .d(chain[i]), .q(chain[i+1]));
		always_ff @(posedge clk) ctx_q[i+1] <= ctx_q[i];
	end

	assign out_vld = chain[NUM_W].vld;
	assign quo     = chain[NUM_W].quo;
	assign out_ctx = ctx_q[NUM_W];
endmodule

// ----- rtl/otp_white_balance_gain_calc_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otp_white_balance_gain_calc_unit
// white balance gains from one calibration record
// ----------------------------------------------------------------------------
// a request is taken whenever start is high and busy is low; busy never rises,
// so one request may follow another in every cycle. each request gives one
// result, shown for a single cycle with done high. the unpack and light
// multiply register loads on the accepting edge; then follow one stage for
// correction and case selection, a chain of 22 restoring division cells, one
// stage to clamp the first gain and set up the second division, 22 more cells
// and the output register, which raises done. the two chains set the
// latency; nothing stalls. the receiver cannot hold a result off.
module otp_white_balance_gain_calc_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic [7:0]  group_flag,
	input  logic [7:0]  red_ratio_high,
	input  logic [7:0]  blue_ratio_high,
	input  logic [7:0]  light_red_high,
	input  logic [7:0]  light_blue_high,
	input  logic [7:0]  packed_low_bits,
	output logic        done,
	output logic [11:0] red_gain,
	output logic [11:0] green_gain,
	output logic [11:0] blue_gain,
	output logic        red_write,
	output logic        green_write,
	output logic        blue_write,
	output logic        used_default,
	output logic [1:0]  status
);
	import awbg_pkg::*;

	// configuration registers
	logic [RATIO_W-1:0] typ_red_q, typ_blue_q, def_red_q, def_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			typ_red_q  <= 10'd318;
			typ_blue_q <= 10'd297;
			def_red_q  <= 10'd315;
			def_blue_q <= 10'd249;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TYP_RED:  typ_red_q  <= cfg_data;
				REG_TYP_BLUE: typ_blue_q <= cfg_data;
				REG_DEF_RED:  def_red_q  <= cfg_data;
				REG_DEF_BLUE: def_blue_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: unpack and multiply by light correction
	logic                vld_s1, def_s1, lr_z_s1, lb_z_s1;
	logic [RATIO_W-1:0]  r_s1, b_s1, tr_s1, tb_s1;
	logic [RATIO_W+RATIO_W:0] rp_s1, bp_s1;
	logic [RATIO_W-1:0]  r_ratio, b_ratio, l_red, l_blue;
	logic                is_def;

	assign is_def  = (group_flag != VALID_MARK);
	assign r_ratio = is_def ? def_red_q  : {red_ratio_high, packed_low_bits[7:6]};
	assign b_ratio = is_def ? def_blue_q : {blue_ratio_high, packed_low_bits[5:4]};
	assign l_red   = is_def ? '0 : {light_red_high, packed_low_bits[3:2]};
	assign l_blue  = is_def ? '0 : {light_blue_high, packed_low_bits[1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		def_s1  <= is_def;
		lr_z_s1 <= (l_red == '0);
		lb_z_s1 <= (l_blue == '0);
		r_s1    <= r_ratio;
		b_s1    <= b_ratio;
		tr_s1   <= typ_red_q;
		tb_s1   <= typ_blue_q;
		rp_s1   <= r_ratio * ({1'b0, l_red} + LIGHT_OFFSET);
		bp_s1   <= b_ratio * ({1'b0, l_blue} + LIGHT_OFFSET);
	end

	// stage 2: corrected ratios, case selection and first division setup
	logic [CR_W-1:0]    rg, bg;
	logic               rg_lo, bg_lo;
	ctx_t               ctx_a;
	logic [NUM_W-1:0]   num_a;
	logic [CR_W-1:0]    den_a;

	// corrected ratio is at most 1533, so it keeps all 11 bits
	assign rg    = lr_z_s1 ? {1'b0, r_s1} : rp_s1[2*RATIO_W:RATIO_W];
	assign bg    = lb_z_s1 ? {1'b0, b_s1} : bp_s1[2*RATIO_W:RATIO_W];
	assign rg_lo = (rg < {1'b0, tr_s1});
	assign bg_lo = (bg < {1'b0, tb_s1});

	always_comb begin
		ctx_a          = '0;
		ctx_a.used_def = def_s1;
		ctx_a.zero_err = (rg == '0) || (bg == '0) || (tr_s1 == '0) || (tb_s1 == '0);
		ctx_a.tr       = tr_s1;
		ctx_a.tb       = tb_s1;
		ctx_a.rg       = rg;
		ctx_a.bg       = bg;
		// first chain gives 1024*bg/tb unless green holds unity
		num_a          = {1'b0, bg, 10'd0};
		den_a          = {1'b0, tb_s1};
		priority if (bg_lo && rg_lo) begin
			// blue gain 1024*tb/bg
			ctx_a.mode = M_GREEN;
			num_a      = {2'b00, tb_s1, 10'd0};
			den_a      = bg;
		end else if (bg_lo) begin
			ctx_a.mode = M_RED;
		end else if (rg_lo) begin
			ctx_a.mode = M_BLUE;
		end else begin
			ctx_a.mode = M_BOTH;
		end
	end

	logic                vld_s2;
	logic [NUM_W-1:0]    num_s2;
	logic [CR_W-1:0]     den_s2;
	ctx_t                ctx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		num_s2 <= num_a;
		den_s2 <= den_a;
		ctx_s2 <= ctx_a;
	end

	// first chain; a parallel chain always forms gr = 1024*rg/tr
	logic               vld_a;
	logic [QUO_W-1:0]   quo_a, quo_r;
	ctx_t               ctx_ao, ctx_ro;
	logic               vld_r;
	logic [NUM_W-1:0]   num_r;

	assign num_r = {1'b0, ctx_s2.rg, 10'd0};

	awbg_divider u_div_a (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s2), .num(num_s2), .den(den_s2),
		.in_ctx(ctx_s2), .out_vld(vld_a), .quo(quo_a), .out_ctx(ctx_ao)
	);

	awbg_divider u_div_r (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s2), .num(num_r),
		.den({1'b0, ctx_s2.tr}),
		.in_ctx(ctx_s2), .out_vld(vld_r), .quo(quo_r), .out_ctx(ctx_ro)
	);

	// stage 3: first gain clamp and second division setup
	logic [1:0]         mode_f;
	logic [GAIN_W-1:0]  g1;
	logic               sat1;
	logic [QUO_W-1:0]   q_first;
	ctx_t               ctx_b;
	logic [NUM_W-1:0]   num_b;
	logic [CR_W-1:0]    den_b;
	logic [RATIO_W-1:0] t_sec;
	logic [GAIN_W+RATIO_W-1:0] prod_b;

	// unity channel for the both-above case follows from the unclamped gains
	always_comb begin
		mode_f = ctx_ao.mode;
		if (ctx_ao.mode == M_BOTH) mode_f = (quo_a > quo_r) ? M_BLUE : M_RED;
		q_first = (mode_f == M_RED) ? quo_r : quo_a;
		sat1    = (q_first > {{(QUO_W-GAIN_W){1'b0}}, GAIN_MAX});
		g1      = sat1 ? GAIN_MAX : q_first[GAIN_W-1:0];
	end

	// derived gain numerator: clamped green gain times the typical ratio
	assign t_sec  = (mode_f == M_RED) ? ctx_ao.tb : ctx_ao.tr;
	assign prod_b = g1 * t_sec;

	always_comb begin
		ctx_b      = ctx_ao;
		ctx_b.mode = mode_f;
		unique case (mode_f)
			M_GREEN: begin
				// red gain 1024*tr/rg
				num_b = {2'b00, ctx_ao.tr, 10'd0};
				den_b = ctx_ao.rg;
			end
			M_RED: begin
				num_b = prod_b;
				den_b = ctx_ao.bg;
			end
			default: begin
				num_b = prod_b;
				den_b = ctx_ao.rg;
			end
		endcase
	end

	logic                vld_s3;
	logic [GAIN_W-1:0]   g1_s3;
	logic                sat1_s3;
	ctx_t                ctx_s3;
	logic [NUM_W-1:0]    num_s3;
	logic [CR_W-1:0]     den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_a;
	end

	always_ff @(posedge clk) begin
		g1_s3   <= g1;
		sat1_s3 <= sat1;
		ctx_s3  <= ctx_b;
		num_s3  <= num_b;
		den_s3  <= den_b;
	end

	// second chain
	logic [QUO_W-1:0] quo_b;
	ctx_t             ctx_bo;
	logic             vld_b;

	awbg_divider u_div_b (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s3),
		.num(num_s3), .den(den_s3),
		.in_ctx(ctx_s3), .out_vld(vld_b), .quo(quo_b), .out_ctx(ctx_bo)
	);

	// first gain and its saturation wait beside the second chain
	logic [GAIN_W-1:0] g1_d [NUM_W+1];
	logic              s1_d [NUM_W+1];
	assign g1_d[0] = g1_s3;
	assign s1_d[0] = sat1_s3;
	for (genvar k = 0; k < NUM_W; k++) begin : g_dly
		always_ff @(posedge clk) begin
			g1_d[k+1] <= g1_d[k];
			s1_d[k+1] <= s1_d[k];
		end
	end

	// output stage
	logic              sat2;
	logic [GAIN_W-1:0] g2, rg_o, gg_o, bg_o;
	logic [1:0]        st_o;

	always_comb begin
		sat2 = (quo_b > {{(QUO_W-GAIN_W){1'b0}}, GAIN_MAX});
		g2   = sat2 ? GAIN_MAX : quo_b[GAIN_W-1:0];
		rg_o = UNITY_GAIN;
		gg_o = UNITY_GAIN;
		bg_o = UNITY_GAIN;
		unique case (ctx_bo.mode)
			M_GREEN: begin
				bg_o = g1_d[NUM_W];
				rg_o = g2;
			end
			M_RED: begin
				gg_o = g1_d[NUM_W];
				bg_o = g2;
			end
			default: begin
				gg_o = g1_d[NUM_W];
				rg_o = g2;
			end
		endcase
		st_o = (s1_d[NUM_W] || sat2) ? ST_SAT : ST_OK;
		if (ctx_bo.zero_err) begin
			rg_o = UNITY_GAIN;
			gg_o = UNITY_GAIN;
			bg_o = UNITY_GAIN;
			st_o = ST_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_b;
	end

	always_ff @(posedge clk) begin
		red_gain     <= rg_o;
		green_gain   <= gg_o;
		blue_gain    <= bg_o;
		red_write    <= (rg_o > UNITY_GAIN);
		green_write  <= (gg_o > UNITY_GAIN);
		blue_write   <= (bg_o > UNITY_GAIN);
		used_default <= ctx_bo.used_def;
		status       <= st_o;
	end

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_chains_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vld_a == vld_r) else $error("divider chains out of step");
	a_ctx_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vld_a |-> ctx_ro == ctx_ao) else $error("divider contexts differ");
	a_zero_unity: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_ZERO |-> red_gain == UNITY_GAIN && !red_write)
		else $error("zero ratio without unity gains");
endmodule
